>>> rtl/core/msp_pkg.sv
// Shared constants, status codes and handshake structs for the minimum-spacing
// point admitter. No dependencies; used by every file in rtl/core.
package msp_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 15;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int ID_BITS    = 10;
    localparam int RAD_BITS   = 8;
    localparam int R2_BITS    = 2 * RAD_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;
    localparam int STAT_BITS  = 3;

    localparam logic [RAD_BITS-1:0] RADIUS_RESET = RAD_BITS'(5);

    typedef enum logic [STAT_BITS-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_SAME_X    = 3'd1,
        ST_SAME_Y    = 3'd2,
        ST_TOO_CLOSE = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
    } probe_t;

    typedef struct packed {
        logic                valid;
        logic                hit;
        status_t             status;
        logic [IDX_BITS-1:0] idx;
    } verdict_t;

endpackage

>>> rtl/core/min_spacing_point_admitter.sv
// Top level of the minimum-spacing point admitter: point store, scan control,
// result register. Depends on msp_pkg and msp_dist_pipe.
//
// Usage: s_valid/s_ready carry one candidate (s_cand_x, s_cand_y) per beat.
// The block scans its stored points from index 0 in order, one stored point
// read per cycle from the point memory, and stops at the first conflict.
// Each candidate gives exactly one m_ beat: accepted flag, status, id of the
// new point, and index of the first conflicting point.
// On a scan the block reads one stored point a cycle through its single memory
// read port, then passes it through the read register and two compare stages;
// with the store full it answers ST_FULL without a scan. The next candidate
// can be taken in the same cycle that m_valid rises.
// One candidate is in work at a time; s_ready is high only between items.
// A finished result waits in the output register while the next candidate
// is taken, so a stalled m_ready holds back the second result, and no further candidate is taken until it drains.
// cfg_valid/cfg_ready write min_radius (reset 5); write it only while idle.
// Reset empties the store (point count zero); no clearing pass is needed.
module min_spacing_point_admitter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msp_pkg::RAD_BITS-1:0]   cfg_min_radius,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [msp_pkg::COORD_BITS-1:0] s_cand_x,
    input  logic [msp_pkg::COORD_BITS-1:0] s_cand_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [msp_pkg::STAT_BITS-1:0]  m_status,
    output logic [msp_pkg::ID_BITS-1:0]    m_point_id,
    output logic [msp_pkg::ID_BITS-1:0]    m_conflict_index
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t                         state_reg;
    logic [msp_pkg::RAD_BITS-1:0]   radius_reg;
    logic [msp_pkg::R2_BITS-1:0]    r2_reg;
    logic [msp_pkg::CNT_BITS-1:0]   count_reg;
    logic [msp_pkg::CNT_BITS-1:0]   issue_reg;
    logic [msp_pkg::COORD_BITS-1:0] cand_x_reg;
    logic [msp_pkg::COORD_BITS-1:0] cand_y_reg;

    logic [msp_pkg::SQ_BITS-1:0]    pts_mem [msp_pkg::MAX_POINTS];
    logic [msp_pkg::SQ_BITS-1:0]    rd_data_reg;
    logic                           rd_valid_reg;
    logic [msp_pkg::IDX_BITS-1:0]   rd_idx_reg;

    logic                           res_accepted_reg;
    msp_pkg::status_t               res_status_reg;
    logic [msp_pkg::ID_BITS-1:0]    res_id_reg;
    logic [msp_pkg::ID_BITS-1:0]    res_conf_reg;

    logic                           m_valid_reg;
    logic                           m_accepted_reg;
    msp_pkg::status_t               m_status_reg;
    logic [msp_pkg::ID_BITS-1:0]    m_point_id_reg;
    logic [msp_pkg::ID_BITS-1:0]    m_conflict_reg;

    msp_pkg::probe_t                probe;
    msp_pkg::verdict_t              verdict;
    logic                           pipe_busy;
    logic                           flush;
    logic                           issue;
    logic                           scan_done;
    logic                           commit;
    logic                           out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign flush     = (state_reg == S_SCAN) && verdict.valid && verdict.hit;
    assign scan_done = (state_reg == S_SCAN) && !flush && (issue_reg == count_reg)
                       && !rd_valid_reg && !pipe_busy;
    assign issue     = (state_reg == S_SCAN) && !flush && (issue_reg < count_reg);
    assign commit    = scan_done;

    assign probe.valid = rd_valid_reg;
    assign probe.idx   = rd_idx_reg;

    // Point store: one write port on commit, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (commit) begin
            pts_mem[count_reg[msp_pkg::IDX_BITS-1:0]] <= {cand_x_reg, cand_y_reg};
        end
        rd_data_reg <= pts_mem[issue_reg[msp_pkg::IDX_BITS-1:0]];
        rd_idx_reg  <= issue_reg[msp_pkg::IDX_BITS-1:0];
    end

    msp_dist_pipe u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flush   (flush),
        .probe   (probe),
        .pt_x    (rd_data_reg[msp_pkg::SQ_BITS-1:msp_pkg::COORD_BITS]),
        .pt_y    (rd_data_reg[msp_pkg::COORD_BITS-1:0]),
        .cand_x  (cand_x_reg),
        .cand_y  (cand_y_reg),
        .r2      (r2_reg),
        .busy    (pipe_busy),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            radius_reg   <= msp_pkg::RADIUS_RESET;
            r2_reg       <= msp_pkg::R2_BITS'(msp_pkg::RADIUS_RESET)
                            * msp_pkg::R2_BITS'(msp_pkg::RADIUS_RESET);
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                radius_reg <= cfg_min_radius;
            end
            r2_reg <= msp_pkg::R2_BITS'(radius_reg) * msp_pkg::R2_BITS'(radius_reg);

            rd_valid_reg <= issue;
            if (issue) begin
                issue_reg <= issue_reg + 1'b1;
            end

            if (m_valid_reg && m_ready && (state_reg != S_RESULT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cand_x_reg <= s_cand_x;
                        cand_y_reg <= s_cand_y;
                        issue_reg  <= '0;
                        if (count_reg >= msp_pkg::CNT_BITS'(msp_pkg::MAX_POINTS)) begin
                            res_accepted_reg <= 1'b0;
                            res_status_reg   <= msp_pkg::ST_FULL;
                            res_id_reg       <= '0;
                            res_conf_reg     <= '0;
                            state_reg        <= S_RESULT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (flush) begin
                        res_accepted_reg <= 1'b0;
                        res_status_reg   <= verdict.status;
                        res_id_reg       <= '0;
                        res_conf_reg     <= msp_pkg::ID_BITS'(verdict.idx);
                        state_reg        <= S_RESULT;
                    end else if (commit) begin
                        res_accepted_reg <= 1'b1;
                        res_status_reg   <= msp_pkg::ST_ACCEPTED;
                        res_id_reg       <= msp_pkg::ID_BITS'(count_reg);
                        res_conf_reg     <= '0;
                        count_reg        <= count_reg + 1'b1;
                        state_reg        <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_accepted_reg <= res_accepted_reg;
                        m_status_reg   <= res_status_reg;
                        m_point_id_reg <= res_id_reg;
                        m_conflict_reg <= res_conf_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = m_accepted_reg;
    assign m_status         = m_status_reg;
    assign m_point_id       = m_point_id_reg;
    assign m_conflict_index = m_conflict_reg;

endmodule

>>> rtl/core/msp_dist_pipe.sv
// Two-stage distance check of the candidate against one stored point per cycle.
// Depends on msp_pkg for widths, status codes and the probe/verdict structs.
module msp_dist_pipe (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              flush,
    input  msp_pkg::probe_t                   probe,
    input  logic [msp_pkg::COORD_BITS-1:0]    pt_x,
    input  logic [msp_pkg::COORD_BITS-1:0]    pt_y,
    input  logic [msp_pkg::COORD_BITS-1:0]    cand_x,
    input  logic [msp_pkg::COORD_BITS-1:0]    cand_y,
    input  logic [msp_pkg::R2_BITS-1:0]       r2,
    output logic                              busy,
    output msp_pkg::verdict_t                 verdict
);

    logic [msp_pkg::COORD_BITS-1:0] dx;
    logic [msp_pkg::COORD_BITS-1:0] dy;
    logic                           s1_valid_reg;
    logic [msp_pkg::IDX_BITS-1:0]   s1_idx_reg;
    logic                           s1_eq_x_reg;
    logic                           s1_eq_y_reg;
    logic [msp_pkg::SQ_BITS-1:0]    s1_sq_x_reg;
    logic [msp_pkg::SQ_BITS-1:0]    s1_sq_y_reg;
    logic [msp_pkg::SUM_BITS-1:0]   sum;
    logic                           close;
    msp_pkg::status_t               status_next;
    msp_pkg::verdict_t              verdict_reg;

    assign dx = (cand_x >= pt_x) ? (cand_x - pt_x) : (pt_x - cand_x);
    assign dy = (cand_y >= pt_y) ? (cand_y - pt_y) : (pt_y - cand_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= probe.valid && !flush;
        end
        s1_idx_reg  <= probe.idx;
        s1_eq_x_reg <= (cand_x == pt_x);
        s1_eq_y_reg <= (cand_y == pt_y);
        s1_sq_x_reg <= msp_pkg::SQ_BITS'(dx) * msp_pkg::SQ_BITS'(dx);
        s1_sq_y_reg <= msp_pkg::SQ_BITS'(dy) * msp_pkg::SQ_BITS'(dy);
    end

    assign sum   = {1'b0, s1_sq_x_reg} + {1'b0, s1_sq_y_reg};
    assign close = (sum <= msp_pkg::SUM_BITS'(r2));

    always_comb begin
        priority if (s1_eq_x_reg) begin
            status_next = msp_pkg::ST_SAME_X;
        end else if (close) begin
            status_next = msp_pkg::ST_TOO_CLOSE;
        end else if (s1_eq_y_reg) begin
            status_next = msp_pkg::ST_SAME_Y;
        end else begin
            status_next = msp_pkg::ST_ACCEPTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verdict_reg.valid <= 1'b0;
        end else begin
            verdict_reg.valid <= s1_valid_reg && !flush;
        end
        verdict_reg.hit    <= (status_next != msp_pkg::ST_ACCEPTED);
        verdict_reg.status <= status_next;
        verdict_reg.idx    <= s1_idx_reg;
    end

    assign verdict = verdict_reg;
    assign busy    = s1_valid_reg || verdict_reg.valid;

endmodule

>>> rtl/core/msp_port_checker.sv
// Port-level checks on the admitter's result channel, bound to the top level.
// Depends on msp_pkg for status codes.
module msp_port_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_accepted,
    input logic [msp_pkg::STAT_BITS-1:0]  m_status,
    input logic [msp_pkg::ID_BITS-1:0]    m_point_id,
    input logic [msp_pkg::ID_BITS-1:0]    m_conflict_index
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_point_id)
            && $stable(m_conflict_index) && $stable(m_accepted))
        else $error("result beat changed while stalled");

    a_acc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_accepted == (m_status == msp_pkg::ST_ACCEPTED)))
        else $error("accepted flag disagrees with status");

    a_reject_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> (m_point_id == '0))
        else $error("rejected beat carries a point id");

    a_no_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_accepted || m_status == msp_pkg::ST_FULL)
            |-> (m_conflict_index == '0))
        else $error("conflict index set without a conflict");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= msp_pkg::ST_FULL))
        else $error("status code out of range");

endmodule

bind min_spacing_point_admitter msp_port_checker u_port_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_accepted       (m_accepted),
    .m_status         (m_status),
    .m_point_id       (m_point_id),
    .m_conflict_index (m_conflict_index)
);

>>> tb/sv/msp_admit_checker.sv
// Result checker for the minimum-spacing point admitter: watches the radius,
// candidate and result channels, keeps its own point store and compares each
// result beat. Depends on msp_pkg.
module msp_admit_checker
    import msp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [RAD_BITS-1:0]   cfg_min_radius,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_cand_x,
    input  logic [COORD_BITS-1:0] s_cand_y,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_accepted,
    input  logic [STAT_BITS-1:0]  m_status,
    input  logic [ID_BITS-1:0]    m_point_id,
    input  logic [ID_BITS-1:0]    m_conflict_index,
    output int                    fail_count,
    output int                    pending_count,
    output int                    stored_count
);

    typedef struct packed {
        logic               accepted;
        status_t            status;
        logic [ID_BITS-1:0] point_id;
        logic [ID_BITS-1:0] conflict_index;
    } outcome_t;

    logic [COORD_BITS-1:0] pts_x [MAX_POINTS];
    logic [COORD_BITS-1:0] pts_y [MAX_POINTS];
    int unsigned           n_pts  = 0;
    logic [RAD_BITS-1:0]   radius = RADIUS_RESET;
    outcome_t              pending_outcomes [$];
    int                    errs   = 0;

    function automatic outcome_t admit_candidate(input logic [COORD_BITS-1:0] cx,
                                                 input logic [COORD_BITS-1:0] cy);
        outcome_t    res;
        int unsigned dx;
        int unsigned dy;
        int unsigned d2;
        int unsigned r2;
        res.accepted       = 1'b0;
        res.status         = ST_ACCEPTED;
        res.point_id       = '0;
        res.conflict_index = '0;
        r2 = 32'(radius) * 32'(radius);
        if (n_pts >= MAX_POINTS) begin
            res.status = ST_FULL;
        end else begin
            for (int j = 0; j < int'(n_pts); j++) begin
                dx = (cx >= pts_x[j]) ? 32'(cx - pts_x[j]) : 32'(pts_x[j] - cx);
                dy = (cy >= pts_y[j]) ? 32'(cy - pts_y[j]) : 32'(pts_y[j] - cy);
                d2 = dx * dx + dy * dy;
                if (cx == pts_x[j])
                    res.status = ST_SAME_X;
                else if (d2 <= r2)
                    res.status = ST_TOO_CLOSE;
                else if (cy == pts_y[j])
                    res.status = ST_SAME_Y;
                if (res.status != ST_ACCEPTED) begin
                    res.conflict_index = ID_BITS'(j);
                    break;
                end
            end
            if (res.status == ST_ACCEPTED) begin
                res.point_id = ID_BITS'(n_pts);
                pts_x[n_pts] = cx;
                pts_y[n_pts] = cy;
                n_pts++;
            end
        end
        res.accepted = (res.status == ST_ACCEPTED);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        outcome_t o;
        if (!aresetn) begin
            n_pts  = 0;
            radius = RADIUS_RESET;
            pending_outcomes.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                radius = cfg_min_radius;
            if (s_valid && s_ready)
                pending_outcomes.insert(pending_outcomes.size(),
                                        admit_candidate(s_cand_x, s_cand_y));
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result beat with no candidate outstanding, status %0d",
                             $time, m_status);
                    errs++;
                end else begin
                    o = pending_outcomes.pop_front();
                    compare_field("accepted", 16'(o.accepted), 16'(m_accepted));
                    compare_field("status", 16'(o.status), 16'(m_status));
                    compare_field("point_id", 16'(o.point_id), 16'(m_point_id));
                    compare_field("conflict_index", 16'(o.conflict_index),
                                  16'(m_conflict_index));
                end
            end
        end
        fail_count    <= errs;
        pending_count <= pending_outcomes.size();
        stored_count  <= n_pts;
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for min_spacing_point_admitter: clock, reset, radius writes,
// candidate stimulus with random gaps and result stalls, and the verdict.
// Depends on msp_pkg, min_spacing_point_admitter and msp_admit_checker.
module tb_top;
    import msp_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [RAD_BITS-1:0]   cfg_min_radius = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_cand_x       = '0;
    logic [COORD_BITS-1:0] s_cand_y       = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_accepted;
    logic [STAT_BITS-1:0]  m_status;
    logic [ID_BITS-1:0]    m_point_id;
    logic [ID_BITS-1:0]    m_conflict_index;

    int                    fail_count;
    int                    pending_count;
    int                    stored_count;
    int                    cycle_count    = 0;
    int                    items_sent     = 0;
    int                    radius_writes  = 0;
    bit                    no_idle        = 1'b0;
    logic [RAD_BITS-1:0]   cur_radius     = RADIUS_RESET;
    logic [COORD_BITS-1:0] sent_x [$];
    logic [COORD_BITS-1:0] sent_y [$];

    always #4 aclk = ~aclk;

    min_spacing_point_admitter i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_min_radius   (cfg_min_radius),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cand_x         (s_cand_x),
        .s_cand_y         (s_cand_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_status         (m_status),
        .m_point_id       (m_point_id),
        .m_conflict_index (m_conflict_index)
    );

    msp_admit_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_min_radius   (cfg_min_radius),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cand_x         (s_cand_x),
        .s_cand_y         (s_cand_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_status         (m_status),
        .m_point_id       (m_point_id),
        .m_conflict_index (m_conflict_index),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .stored_count     (stored_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // hold ready low for a random number of cycles per result beat
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic offer_point(input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_cand_x = x;
        s_cand_y = y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_x.insert(sent_x.size(), x);
        sent_y.insert(sent_y.size(), y);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_radius(input logic [RAD_BITS-1:0] r);
        hold_until_drained();
        cfg_valid      = 1'b1;
        cfg_min_radius = r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid  = 1'b0;
        cur_radius = r;
        radius_writes++;
    endtask

    function automatic logic [COORD_BITS-1:0] edge_coord();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return COORD_BITS'(1);
            2:       return '1 - COORD_BITS'(1);
            default: return '1;
        endcase
    endfunction

    task automatic offer_random_point();
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        int                    pick;
        int                    k;
        int                    span;
        pick = $urandom_range(0, 99);
        if (pick < 40 || sent_x.size() == 0) begin
            x = COORD_BITS'($urandom);
            y = COORD_BITS'($urandom);
        end else if (pick < 85) begin
            k    = $urandom_range(0, sent_x.size() - 1);
            span = int'(cur_radius) + 2;
            case ($urandom_range(0, 2))
                0: begin
                    x = sent_x[k];
                    y = COORD_BITS'($urandom);
                end
                1: begin
                    x = COORD_BITS'($urandom);
                    y = sent_y[k];
                end
                default: begin
                    x = sent_x[k] + COORD_BITS'($urandom_range(0, 2 * span)) - COORD_BITS'(span);
                    y = sent_y[k] + COORD_BITS'($urandom_range(0, 2 * span)) - COORD_BITS'(span);
                end
            endcase
        end else begin
            x = edge_coord();
            y = edge_coord();
        end
        offer_point(x, y);
    endtask

    initial begin
        logic [RAD_BITS-1:0] radii [6];
        radii = '{8'd1, 8'd37, 8'd128, 8'd255, 8'd0, 8'd200};
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // reset radius: corners, each conflict kind, exact boundary, first match wins
        offer_point(15'd0, 15'd0);
        offer_point(15'd32767, 15'd32767);
        offer_point(15'd0, 15'd100);
        offer_point(15'd100, 15'd32767);
        offer_point(15'd3, 15'd4);
        offer_point(15'd3, 15'd5);
        offer_point(15'd32764, 15'd32763);
        offer_point(15'd32765, 15'd32767);
        offer_point(15'd32760, 15'd32767);
        offer_point(15'd3, 15'd30000);
        offer_point(15'd20000, 15'd10000);
        offer_point(15'd0, 15'd5);
        offer_point(15'd5, 15'd5);

        set_radius(8'd0);
        offer_point(15'd20001, 15'd10001);
        offer_point(15'd20000, 15'd9999);
        offer_point(15'd20002, 15'd10002);

        set_radius(8'd255);
        offer_point(15'd32614, 15'd32563);
        offer_point(15'd32613, 15'd32563);

        foreach (radii[i]) begin
            set_radius(radii[i]);
            no_idle = (i == 2);
            repeat (91) offer_random_point();
        end
        no_idle = 1'b0;

        // widest radius against the grown store, then the extreme corners
        set_radius(8'd255);
        repeat (12) offer_random_point();
        offer_point('0, '0);
        offer_point('1, '1);

        hold_until_drained();
        repeat (40) @(negedge aclk);

        $display("Sent %0d candidates across %0d radius writes; store ended with %0d points.",
                 items_sent, radius_writes, stored_count);
        $display("Checked accepted flag, status, id and conflict index of every result.");
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> min_spacing_point_admitter.f
rtl/core/msp_pkg.sv
rtl/core/msp_dist_pipe.sv
rtl/core/min_spacing_point_admitter.sv
rtl/core/msp_port_checker.sv
tb/sv/msp_admit_checker.sv
tb/sv/tb_top.sv
